// ===== src/atan2_pkg.sv =====
// ----------------------------------------------------------------------------
// atan2_pkg
// shared widths, constants and types of the rational atan2 pipeline
// ----------------------------------------------------------------------------
package atan2_pkg;

    localparam int COORD_W  = 32;   // input coordinate width
    localparam int NARROW_W = 8;    // magnitude width after normalizing shift
    localparam int PROD_W   = 2 * NARROW_W;
    localparam int NUM_W    = 32;   // 60937 * x * y stays below 2^32
    localparam int DEN_W    = 23;   // 61*x*x + 17*y*y stays below 2^23
    localparam int QUOT_W   = 10;   // first-octant angle is at most 781
    localparam int ANGLE_W  = 13;
    localparam int UNF_W    = 18;   // signed width of the unfolding arithmetic
    localparam int TURN_W   = 17;   // width of the turn constants
    localparam int SHIFT_W  = $clog2(COORD_W);

    localparam logic [PROD_W-1:0] NUM_K  = PROD_W'(60937);
    localparam logic [6:0]        DEN_KX = 7'd61;
    localparam logic [6:0]        DEN_KY = 7'd17;

    localparam logic [TURN_W-1:0] QUARTER_TURN_DEF = TURN_W'(1571);
    localparam logic [TURN_W-1:0] HALF_TURN_DEF    = TURN_W'(3142);
    localparam logic [TURN_W-1:0] FULL_TURN_DEF    = TURN_W'(6283);

    // octant folding decisions that travel with each request
    typedef struct packed {
        logic swapped;
        logic xneg;
        logic yneg;
    } atan2_flags_t;

endpackage

// ===== src/atan2_fold.sv =====
// ----------------------------------------------------------------------------
// atan2_fold
// two stages: sign fold and swap, then joint normalizing shift to 8 bits
// ----------------------------------------------------------------------------
module atan2_fold (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [atan2_pkg::COORD_W-1:0] coord_y,
    input  logic signed [atan2_pkg::COORD_W-1:0] coord_x,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [atan2_pkg::NARROW_W-1:0]      ax,
    output logic [atan2_pkg::NARROW_W-1:0]      ay,
    output atan2_pkg::atan2_flags_t             flags
);
    import atan2_pkg::*;

    logic                v1_reg, v2_reg;
    logic                en1, en2;
    logic [COORD_W-1:0]  big_reg, big_next;
    logic [COORD_W-1:0]  small_reg, small_next;
    atan2_flags_t        flg1_reg, flg1_next;
    logic [NARROW_W-1:0] ax_reg, ax_next;
    logic [NARROW_W-1:0] ay_reg, ay_next;
    atan2_flags_t        flg2_reg;
    logic [COORD_W-1:0]  mag_x, mag_y;
    logic [SHIFT_W-1:0]  msb;
    logic [SHIFT_W-1:0]  shift;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // magnitudes as unsigned, so the most negative input folds cleanly
    always_comb
    begin
        mag_x = coord_x[COORD_W-1] ? (COORD_W'(0) - coord_x) : coord_x;
        mag_y = coord_y[COORD_W-1] ? (COORD_W'(0) - coord_y) : coord_y;
        flg1_next.xneg    = coord_x[COORD_W-1];
        flg1_next.yneg    = coord_y[COORD_W-1];
        flg1_next.swapped = mag_y > mag_x;
        big_next   = flg1_next.swapped ? mag_y : mag_x;
        small_next = flg1_next.swapped ? mag_x : mag_y;
    end

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < COORD_W; i++)
        begin
            if (big_reg[i])
            begin
                msb = SHIFT_W'(i);
            end
        end
        shift   = (msb > SHIFT_W'(NARROW_W - 1)) ? (msb - SHIFT_W'(NARROW_W - 1)) : '0;
        ax_next = NARROW_W'(big_reg >> shift);
        ay_next = NARROW_W'(small_reg >> shift);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            big_reg   <= big_next;
            small_reg <= small_next;
            flg1_reg  <= flg1_next;
        end
        if (en2 && v1_reg)
        begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            flg2_reg <= flg1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign ax        = ax_reg;
    assign ay        = ay_reg;
    assign flags     = flg2_reg;

endmodule

// ===== src/atan2_mul.sv =====
// ----------------------------------------------------------------------------
// atan2_mul
// two stages: 8x8 products, then constant scaling into numerator and denominator
// ----------------------------------------------------------------------------
module atan2_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [atan2_pkg::NARROW_W-1:0] ax,
    input  logic [atan2_pkg::NARROW_W-1:0] ay,
    input  atan2_pkg::atan2_flags_t        in_flags,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [atan2_pkg::NUM_W-1:0]    num,
    output logic [atan2_pkg::DEN_W-1:0]    den,
    output atan2_pkg::atan2_flags_t        out_flags
);
    import atan2_pkg::*;

    logic               v1_reg, v2_reg;
    logic               en1, en2;
    logic [PROD_W-1:0]  xy_reg, xy_next;
    logic [PROD_W-1:0]  xx_reg, xx_next;
    logic [PROD_W-1:0]  yy_reg, yy_next;
    atan2_flags_t       flg1_reg, flg2_reg;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        xy_next  = ax * ay;
        xx_next  = ax * ax;
        yy_next  = ay * ay;
        num_next = NUM_W'(NUM_K) * NUM_W'(xy_reg);
        den_next = DEN_W'(DEN_KX) * DEN_W'(xx_reg) + DEN_W'(DEN_KY) * DEN_W'(yy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            xy_reg   <= xy_next;
            xx_reg   <= xx_next;
            yy_reg   <= yy_next;
            flg1_reg <= in_flags;
        end
        if (en2 && v1_reg)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            flg2_reg <= flg1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign out_flags = flg2_reg;

endmodule

// ===== src/atan2_div.sv =====
// ----------------------------------------------------------------------------
// atan2_div
// pipelined restoring divider, one quotient bit per stage, msb first
// ----------------------------------------------------------------------------
module atan2_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [atan2_pkg::NUM_W-1:0]   num,
    input  logic [atan2_pkg::DEN_W-1:0]   den,
    input  atan2_pkg::atan2_flags_t       in_flags,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [atan2_pkg::QUOT_W-1:0]  quot,
    output logic [atan2_pkg::DEN_W-1:0]   out_den,
    output atan2_pkg::atan2_flags_t       out_flags
);
    import atan2_pkg::*;

    logic [QUOT_W-1:0] v_reg;
    logic [QUOT_W-1:0] en;
    logic [NUM_W-1:0]  rem_reg [QUOT_W];
    logic [QUOT_W-1:0] q_reg   [QUOT_W];
    logic [DEN_W-1:0]  den_reg [QUOT_W];
    atan2_flags_t      flg_reg [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_stage
        localparam int BIT = QUOT_W - 1 - k;

        logic              v_in;
        logic [NUM_W-1:0]  rem_in;
        logic [QUOT_W-1:0] q_in;
        logic [DEN_W-1:0]  den_in;
        atan2_flags_t      flg_in;
        logic [NUM_W:0]    trial;
        logic              take;
        logic [NUM_W-1:0]  rem_next;
        logic [QUOT_W-1:0] q_next;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = num;
            assign q_in   = '0;
            assign den_in = den;
            assign flg_in = in_flags;
        end
        else
        begin : g_next
            assign v_in   = v_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
            assign flg_in = flg_reg[k-1];
        end

        if (k == QUOT_W - 1)
        begin : g_last
            assign en[k] = !v_reg[k] || out_ready;
        end
        else
        begin : g_mid
            assign en[k] = !v_reg[k] || en[k+1];
        end

        // quotient never reaches 2^QUOT_W, so the top trial divisor fits
        always_comb
        begin
            trial    = (NUM_W + 1)'(den_in) << BIT;
            take     = {1'b0, rem_in} >= trial;
            rem_next = take ? (rem_in - trial[NUM_W-1:0]) : rem_in;
            q_next   = take ? (q_in | (QUOT_W'(1) << BIT)) : q_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k] && v_in)
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                den_reg[k] <= den_in;
                flg_reg[k] <= flg_in;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[QUOT_W-1];
    assign quot      = q_reg[QUOT_W-1];
    assign out_den   = den_reg[QUOT_W-1];
    assign out_flags = flg_reg[QUOT_W-1];

endmodule

// ===== src/atan2_angle_approximation_top.sv =====
// throughput: one request per cycle while the output is not stalled; the ten-stage divider sets the depth
// each stage holds its own valid bit, so bubbles close up under output back-pressure
// reset: asynchronous, active low, clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// atan2_angle_approximation_top
// angle of (x, y) in milliradians by rational approximation with octant folding
// ----------------------------------------------------------------------------
module atan2_angle_approximation_top #(
    parameter logic [atan2_pkg::TURN_W-1:0] QUARTER_TURN = atan2_pkg::QUARTER_TURN_DEF,
    parameter logic [atan2_pkg::TURN_W-1:0] HALF_TURN    = atan2_pkg::HALF_TURN_DEF,
    parameter logic [atan2_pkg::TURN_W-1:0] FULL_TURN    = atan2_pkg::FULL_TURN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [atan2_pkg::COORD_W-1:0] coord_y,
    input  logic signed [atan2_pkg::COORD_W-1:0] coord_x,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [atan2_pkg::ANGLE_W-1:0]        angle_mrad
);
    import atan2_pkg::*;

    localparam logic signed [UNF_W-1:0] QUARTER_S = UNF_W'(QUARTER_TURN);
    localparam logic signed [UNF_W-1:0] HALF_S    = UNF_W'(HALF_TURN);
    localparam logic signed [UNF_W-1:0] FULL_S    = UNF_W'(FULL_TURN);

    logic                fold_valid, fold_ready;
    logic [NARROW_W-1:0] fold_ax, fold_ay;
    atan2_flags_t        fold_flags;
    logic                mul_valid, mul_ready;
    logic [NUM_W-1:0]    mul_num;
    logic [DEN_W-1:0]    mul_den;
    atan2_flags_t        mul_flags;
    logic                div_valid, div_ready;
    logic [QUOT_W-1:0]   div_quot;
    logic [DEN_W-1:0]    div_den;
    atan2_flags_t        div_flags;

    logic                      out_valid_reg;
    logic [ANGLE_W-1:0]        angle_reg, angle_next;
    logic signed [UNF_W-1:0]   val_q, val_h, val_f;

    atan2_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .coord_y   (coord_y),
        .coord_x   (coord_x),
        .out_valid (fold_valid),
        .out_ready (fold_ready),
        .ax        (fold_ax),
        .ay        (fold_ay),
        .flags     (fold_flags)
    );

    atan2_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fold_valid),
        .in_ready  (fold_ready),
        .ax        (fold_ax),
        .ay        (fold_ay),
        .in_flags  (fold_flags),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .num       (mul_num),
        .den       (mul_den),
        .out_flags (mul_flags)
    );

    atan2_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .num       (mul_num),
        .den       (mul_den),
        .in_flags  (mul_flags),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .quot      (div_quot),
        .out_den   (div_den),
        .out_flags (div_flags)
    );

    assign div_ready = !out_valid_reg || out_ready;

    // unfold quarter, half, then full turn; exact signed values keep the zero test right
    always_comb
    begin
        val_q = div_flags.swapped ? (QUARTER_S - UNF_W'(div_quot)) : UNF_W'(div_quot);
        val_h = div_flags.xneg ? (HALF_S - val_q) : val_q;
        val_f = (div_flags.yneg && (val_h != '0)) ? (FULL_S - val_h) : val_h;
        angle_next = (div_den == '0) ? '0 : val_f[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_ready)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ready && div_valid)
        begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign angle_mrad = angle_reg;

endmodule

// ===== src/atan2_chk.sv =====
// ----------------------------------------------------------------------------
// atan2_chk
// port-level checks of the angle pipeline, bound to the top level
// ----------------------------------------------------------------------------
module atan2_chk #(
    parameter logic [atan2_pkg::TURN_W-1:0] FULL_TURN = atan2_pkg::FULL_TURN_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [atan2_pkg::ANGLE_W-1:0] angle_mrad
);
    import atan2_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle_mrad))
    else $error("result changed while stalled");

    // an empty output register means every stage can move, so a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("request refused with empty output");

    // back-pressure only comes from the output side
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
    else $error("request refused while output drains");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, angle_mrad} <= (ANGLE_W + 1)'(FULL_TURN)))
    else $error("angle above full turn");

endmodule

bind atan2_angle_approximation_top atan2_chk #(
    .FULL_TURN (FULL_TURN)
) u_atan2_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .angle_mrad (angle_mrad)
);

// ===== tb/atan2_angle_approximation_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_angle_approximation_top_tb
// drives (y, x) requests through the angle pipeline with random gaps and
// back-pressure, predicts each angle in milliradians and compares it in order
// ----------------------------------------------------------------------------
module atan2_angle_approximation_top_tb;

    import atan2_pkg::*;

    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int STEADY_FIRST   = 300;
    localparam int STEADY_LAST    = 499;
    localparam int HOLD_AT_ITEM   = 650;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int IDLE_PERCENT   = 20;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 200000;

    // scoreboard: holds the angles predicted for accepted requests
    class angle_scoreboard;
        localparam logic [31:0] QTR_TURN  = 32'd1571;
        localparam logic [31:0] HALF_TURN = 32'd3142;
        localparam logic [31:0] FULL_TURN = 32'd6283;
        localparam logic [63:0] NUMER_K   = 64'd60937;
        localparam logic [63:0] DENOM_KX  = 64'd61;
        localparam logic [63:0] DENOM_KY  = 64'd17;

        logic [ANGLE_W-1:0] pending_angles[$];
        int                 errors;

        function new();
            errors = 0;
        endfunction

        function automatic logic [ANGLE_W-1:0] predict_angle(logic [31:0] y_raw,
                                                               logic [31:0] x_raw);
            logic        x_neg;
            logic        y_neg;
            logic        swapped;
            logic [31:0] mag_x;
            logic [31:0] mag_y;
            logic [31:0] tmp;
            logic [31:0] turned;
            logic [63:0] numer;
            logic [63:0] denom;
            x_neg = x_raw[31];
            y_neg = y_raw[31];
            mag_x = x_neg ? (32'd0 - x_raw) : x_raw;
            mag_y = y_neg ? (32'd0 - y_raw) : y_raw;
            swapped = (mag_y > mag_x);
            if (swapped)
            begin
                tmp   = mag_x;
                mag_x = mag_y;
                mag_y = tmp;
            end
            // narrow both magnitudes together until x fits in 8 bits
            while (mag_x[31:8] != 24'd0)
            begin
                mag_x = mag_x >> 1;
                mag_y = mag_y >> 1;
            end
            numer = NUMER_K * {32'd0, mag_y} * {32'd0, mag_x};
            denom = DENOM_KX * {32'd0, mag_x} * {32'd0, mag_x}
                  + DENOM_KY * {32'd0, mag_y} * {32'd0, mag_y};
            if (denom == 64'd0)
                return '0;
            turned = 32'(numer / denom);
            if (swapped)
                turned = QTR_TURN - turned;
            if (x_neg)
                turned = HALF_TURN - turned;
            if (y_neg && turned != 32'd0)
                turned = FULL_TURN - turned;
            return turned[ANGLE_W-1:0];
        endfunction

        function void note_request(logic [31:0] y_raw, logic [31:0] x_raw);
            pending_angles.push_back(predict_angle(y_raw, x_raw));
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [ANGLE_W-1:0] got);
            logic [ANGLE_W-1:0] want;
            if (pending_angles.size() == 0)
            begin
                report_mismatch($sformatf("angle %0d with no pending request", got));
            end
            else
            begin
                want = pending_angles.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("angle_mrad got %0d, predicted %0d", got, want));
            end
        endtask

        function int pending();
            return pending_angles.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_x;
    logic                       out_valid;
    logic                       out_ready;
    logic [ANGLE_W-1:0]         angle_mrad;

    logic                       steady;
    int                         hold_trigger;
    int                         cycle_count;
    angle_scoreboard            sb;

    atan2_angle_approximation_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .coord_y    (coord_y),
        .coord_x    (coord_x),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .angle_mrad (angle_mrad)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF_NS) clk = ~clk;

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // monitor: note accepted requests and check delivered angles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(coord_y, coord_x);
            if (out_valid && out_ready)
                sb.check_result(angle_mrad);
        end
    end

    // receiver: random stalls, steady stretch and one long hold-off
    initial
    begin
        int holds_seen;
        int hold_left;
        out_ready  = 1'b0;
        holds_seen = 0;
        hold_left  = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_trigger)
            begin
                holds_seen = hold_trigger;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic send_request(input logic [31:0] y, input logic [31:0] x,
                                input bit may_idle);
        bit took;
        if (may_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        coord_y  <= y;
        coord_x  <= x;
        // in_ready is settled by the falling edge and holds until the next rise
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    function automatic logic [31:0] random_coord();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 600)) - 32'd300;
            2:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    v = 32'd0 - v;
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h8000_0000 + 32'($urandom_range(0, 255));
                    3: v = 32'h7FFF_FFFF - 32'($urandom_range(0, 255));
                    default: v = 32'd0;
                endcase
            end
        endcase
        return v;
    endfunction

    initial
    begin
        logic [31:0] ry;
        logic [31:0] rx;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        coord_y      = '0;
        coord_x      = '0;
        steady       = 1'b0;
        hold_trigger = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // origin, axes, most negative values, equal magnitudes, zero angle with y < 0
        send_request(32'd0, 32'd0, 1'b1);
        send_request(32'd0, 32'd1, 1'b1);
        send_request(32'd1, 32'd0, 1'b1);
        send_request(32'd0, 32'hFFFF_FFFF, 1'b1);
        send_request(32'hFFFF_FFFF, 32'd0, 1'b1);
        send_request(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_request(32'd0, 32'h8000_0000, 1'b1);
        send_request(32'h8000_0000, 32'd0, 1'b1);
        send_request(32'd5, 32'd5, 1'b1);
        send_request(32'd0 - 32'd5, 32'd5, 1'b1);
        send_request(32'd5, 32'd0 - 32'd5, 1'b1);
        send_request(32'd0 - 32'd5, 32'd0 - 32'd5, 1'b1);
        send_request(32'hFFFF_FFFF, 32'd1000, 1'b1);
        send_request(32'hFFFF_FFFF, 32'd0 - 32'd1000, 1'b1);
        send_request(32'd255, 32'd255, 1'b1);
        send_request(32'd256, 32'd255, 1'b1);
        send_request(32'd3, 32'd7, 1'b1);
        send_request(32'd0 - 32'd7, 32'd3, 1'b1);
        send_request(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == STEADY_FIRST)
                steady <= 1'b1;
            if (i == STEADY_LAST + 1)
                steady <= 1'b0;
            if (i == HOLD_AT_ITEM)
                hold_trigger <= hold_trigger + 1;
            rx = random_coord();
            if ($urandom_range(0, 9) == 0)
                ry = ($urandom_range(0, 1) == 1) ? (32'd0 - rx) : rx;
            else
                ry = random_coord();
            send_request(ry, rx, !(i >= STEADY_FIRST && i <= STEADY_LAST));
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
